/* hdl/aroc_pkg.sv */
// shared types and constants for the accuraterip offset checksum core
package aroc_pkg;

	localparam int FRAME_W    = 29;
	localparam int TOTAL_W    = 28;
	localparam int RANGE_W    = 14;
	localparam int EDGE_W     = 16;
	localparam int V2OFF_W    = 13;
	localparam int SUM_W      = 32;
	localparam int SAMPLE_W   = 16;
	localparam int KIND_W     = 2;
	localparam int OFFSET_W   = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	localparam int CD_RATE    = 44100;
	localparam int SECTOR_DIV = 75;
	localparam int EDGE_SECT  = 5;
	localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'((CD_RATE / SECTOR_DIV) * EDGE_SECT);

	localparam int QDEPTH     = 8;
	localparam int QPTR_W     = 3;
	localparam int QCNT_W     = 4;
	localparam int PIPE_DEPTH = 4;
	localparam int PEND_W     = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_V1     = 2'd0,
		KIND_V2     = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_FRAMES = 3'd0,
		REG_FRAME_RANGE  = 3'd1,
		REG_FIRST_TRACK  = 3'd2,
		REG_LAST_TRACK   = 3'd3,
		REG_EDGE_FRAMES  = 3'd4,
		REG_V2_OFFSET    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SUM_W-1:0]   start_m1;
		logic [TOTAL_W-1:0] end_frame;
	} cfg_view_t;

	typedef struct packed {
		logic                reject;
		logic                win;
		logic                tail;
		logic                a_ok;
		logic                a_fwd;
		logic                b_ok;
		logic                b_fwd;
		logic                v2_in;
		logic                emit;
		logic                base_hit;
		logic                is_final;
		logic [OFFSET_W-1:0] offset;
		logic [SUM_W-1:0]    sample;
		logic [FRAME_W-1:0]  idx;
		logic [FRAME_W-1:0]  v2_idx;
	} item_ctl_t;

	typedef struct packed {
		logic                reject;
		logic                v2;
		logic [OFFSET_W-1:0] offset;
		logic [SUM_W-1:0]    csum1;
		logic [SUM_W-1:0]    csum2;
	} res_entry_t;

endpackage

/* hdl/aroc_if.sv */
// channel interfaces for frames, results and register writes
interface aroc_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [aroc_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [aroc_pkg::SAMPLE_W-1:0] right_sample;

	modport source(output valid, left_sample, right_sample, input ready);
	modport sink(input valid, left_sample, right_sample, output ready);
endinterface

interface aroc_out_if;
	logic                          valid;
	logic                          ready;
	logic [aroc_pkg::KIND_W-1:0]   kind;
	logic [aroc_pkg::OFFSET_W-1:0] offset;
	logic [aroc_pkg::SUM_W-1:0]    checksum;
	logic                          last;

	modport source(output valid, kind, offset, checksum, last, input ready);
	modport sink(input valid, kind, offset, checksum, last, output ready);
endinterface

interface aroc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [aroc_pkg::CFG_IDX_W-1:0]  index;
	logic [aroc_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hdl/aroc_ram.sv */
// simple dual-port ram with registered read
module aroc_ram #(
	parameter int AW    = 13,
	parameter int DEPTH = 8191
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [aroc_pkg::SUM_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [aroc_pkg::SUM_W-1:0] rdata
);

	logic [aroc_pkg::SUM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/aroc_ctrl.sv */
// configuration registers, frame counters and fifo address control
module aroc_ctrl #(
	parameter int MAX_RANGE = 8192,
	parameter int AW        = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	aroc_cfg_if.sink                      cfg,
	input  logic                          accept,
	input  logic [aroc_pkg::SAMPLE_W-1:0] left_sample,
	input  logic [aroc_pkg::SAMPLE_W-1:0] right_sample,
	output logic                          lead_we,
	output logic [AW-1:0]                 lead_waddr,
	output logic                          trail_we,
	output logic [AW-1:0]                 trail_waddr,
	output logic [aroc_pkg::SUM_W-1:0]    wdata,
	output logic [AW-1:0]                 raddr,
	output aroc_pkg::cfg_view_t           cfg_view,
	output logic                          valid_s1,
	output aroc_pkg::item_ctl_t           ctl_s1
);

	localparam int RNG_W = ($clog2(MAX_RANGE + 1) > aroc_pkg::RANGE_W) ?
		$clog2(MAX_RANGE + 1) : aroc_pkg::RANGE_W;
	localparam int FW = aroc_pkg::FRAME_W;
	localparam int TW = aroc_pkg::TOTAL_W;

	logic [TW-1:0]                  total_q;
	logic [aroc_pkg::RANGE_W-1:0]   range_q;
	logic                           first_q;
	logic                           last_q;
	logic [aroc_pkg::EDGE_W-1:0]    edge_q;
	logic [aroc_pkg::V2OFF_W-1:0]   v2off_q;

	logic [FW-1:0]                  index_q;
	logic [AW-1:0]                  lc_q;
	logic [AW-1:0]                  tc_q;
	logic [FW-1:0]                  v2_idx_q;
	logic [aroc_pkg::V2OFF_W-1:0]   v2_skip_q;

	logic [TW-1:0]                  tot;
	logic [RNG_W-1:0]               rng;
	logic [AW-1:0]                  cap;
	logic [FW-1:0]                  final_i;
	logic [aroc_pkg::EDGE_W-1:0]    start;
	logic [TW-1:0]                  end_frame;
	logic                           reject;
	logic                           after_start;
	logic                           lead_wr;
	logic                           trail_wr;
	logic [FW-1:0]                  rel;
	logic [AW-1:0]                  rd;
	logic [AW-1:0]                  lc_new;
	logic [AW-1:0]                  tc_new;
	logic                           v2_run;
	logic [FW-1:0]                  v2_eff;
	logic [aroc_pkg::SUM_W-1:0]     sample;
	aroc_pkg::item_ctl_t            ctl_d;

	assign cfg.ready = 1'b1;

	always_comb begin
		tot = (total_q == '0) ? TW'(1) : total_q;
		if (range_q == '0) begin
			rng = RNG_W'(1);
		end else if (RNG_W'(range_q) > RNG_W'(MAX_RANGE)) begin
			rng = RNG_W'(MAX_RANGE);
		end else begin
			rng = RNG_W'(range_q);
		end
		cap     = AW'(rng - RNG_W'(1));
		final_i = FW'(tot) + FW'(rng) - FW'(1);
		start   = first_q ? edge_q : aroc_pkg::EDGE_W'(1);
		if (last_q) begin
			end_frame = (tot >= TW'(edge_q)) ? tot - TW'(edge_q) : '0;
		end else begin
			end_frame = tot;
		end
		reject      = index_q > final_i;
		after_start = index_q >= FW'(start);
		lead_wr     = !reject && after_start && (lc_q < cap);
		trail_wr    = !reject && (index_q > FW'(end_frame)) && (tc_q < cap);
		rel         = index_q - FW'(tot);
		rd          = AW'(rel - FW'(1));
		lc_new      = lc_q + AW'(lead_wr);
		tc_new      = tc_q + AW'(trail_wr);
		v2_run      = v2_skip_q == '0;
		v2_eff      = (FW'(v2off_q) < FW'(cap)) ? FW'(v2off_q) : FW'(cap);
		sample      = {right_sample, left_sample};
	end

	always_comb begin
		ctl_d.reject   = reject;
		ctl_d.win      = after_start && (index_q <= FW'(end_frame));
		ctl_d.tail     = index_q > FW'(tot);
		ctl_d.a_ok     = ctl_d.tail && (rd < lc_new);
		ctl_d.a_fwd    = lead_wr && (lc_q == rd);
		ctl_d.b_ok     = ctl_d.tail && (rd < tc_new);
		ctl_d.b_fwd    = trail_wr && (tc_q == rd);
		ctl_d.v2_in    = v2_run && (v2_idx_q >= FW'(start)) && (v2_idx_q <= FW'(end_frame));
		ctl_d.emit     = !reject && (index_q >= FW'(tot));
		ctl_d.base_hit = rel == v2_eff;
		ctl_d.is_final = index_q == final_i;
		ctl_d.offset   = rel[aroc_pkg::OFFSET_W-1:0];
		ctl_d.sample   = sample;
		ctl_d.idx      = index_q;
		ctl_d.v2_idx   = v2_idx_q;
	end

	assign lead_we            = accept && lead_wr;
	assign lead_waddr         = lc_q;
	assign trail_we           = accept && trail_wr;
	assign trail_waddr        = tc_q;
	assign wdata              = sample;
	assign raddr              = rd;
	assign cfg_view.start_m1  = aroc_pkg::SUM_W'(start) - aroc_pkg::SUM_W'(1);
	assign cfg_view.end_frame = end_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= TW'(1);
			range_q   <= aroc_pkg::RANGE_W'(1);
			first_q   <= 1'b0;
			last_q    <= 1'b0;
			edge_q    <= aroc_pkg::EDGE_RESET;
			v2off_q   <= '0;
			index_q   <= FW'(1);
			lc_q      <= '0;
			tc_q      <= '0;
			v2_idx_q  <= FW'(1);
			v2_skip_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					aroc_pkg::REG_TOTAL_FRAMES: total_q <= cfg.data[TW-1:0];
					aroc_pkg::REG_FRAME_RANGE:  range_q <= cfg.data[aroc_pkg::RANGE_W-1:0];
					aroc_pkg::REG_FIRST_TRACK:  first_q <= cfg.data[0];
					aroc_pkg::REG_LAST_TRACK:   last_q  <= cfg.data[0];
					aroc_pkg::REG_EDGE_FRAMES:  edge_q  <= cfg.data[aroc_pkg::EDGE_W-1:0];
					aroc_pkg::REG_V2_OFFSET: begin
						v2off_q   <= cfg.data[aroc_pkg::V2OFF_W-1:0];
						v2_skip_q <= cfg.data[aroc_pkg::V2OFF_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept && !reject) begin
				index_q <= index_q + FW'(1);
				if (lead_wr) begin
					lc_q <= lc_new;
				end
				if (trail_wr) begin
					tc_q <= tc_new;
				end
				if (v2_run) begin
					v2_idx_q <= v2_idx_q + FW'(1);
				end else begin
					v2_skip_q <= v2_skip_q - aroc_pkg::V2OFF_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl_d;
	end

endmodule

/* hdl/aroc_dp.sv */
// product stage and checksum accumulators
module aroc_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  aroc_pkg::item_ctl_t        ctl_s1,
	input  aroc_pkg::cfg_view_t        cfg_view,
	input  logic [aroc_pkg::SUM_W-1:0] lead_rdata,
	input  logic [aroc_pkg::SUM_W-1:0] trail_rdata,
	output logic                       done,
	output logic                       push,
	output aroc_pkg::res_entry_t       entry
);

	localparam int SW = aroc_pkg::SUM_W;
	localparam int PW = aroc_pkg::SUM_W + aroc_pkg::FRAME_W;

	logic [SW-1:0]       a_s1;
	logic [SW-1:0]       b_s1;
	logic [PW-1:0]       p_v2_full;

	logic                valid_s2;
	aroc_pkg::item_ctl_t ctl_s2;
	logic [SW-1:0]       p_vi_s2;
	logic [SW-1:0]       p_eb_s2;
	logic [SW-1:0]       p_sa_s2;
	logic [SW-1:0]       v2hi_s2;
	logic [SW-1:0]       a_s2;
	logic [SW-1:0]       b_s2;

	logic [SW-1:0]       win_v;
	logic [SW-1:0]       delta;
	logic [SW-1:0]       vsd;

	logic                valid_s3;
	aroc_pkg::item_ctl_t ctl_s3;
	logic [SW-1:0]       delta_s3;
	logic [SW-1:0]       vsd_s3;
	logic [SW-1:0]       v2d_s3;

	logic [SW-1:0]       rc_q;
	logic [SW-1:0]       vs_q;
	logic [SW-1:0]       v2s_q;
	logic [SW-1:0]       base_q;
	logic [SW-1:0]       rc_next;

	logic                valid_s4;
	aroc_pkg::item_ctl_t ctl_s4;

	// same-frame fifo write is forwarded over the stale read
	assign a_s1 = ctl_s1.a_ok ? (ctl_s1.a_fwd ? ctl_s1.sample : lead_rdata) : '0;
	assign b_s1 = ctl_s1.b_ok ? (ctl_s1.b_fwd ? ctl_s1.sample : trail_rdata) : '0;
	assign p_v2_full = PW'(ctl_s1.sample) * PW'(ctl_s1.v2_idx);

	always_ff @(posedge clk) begin
		ctl_s2  <= ctl_s1;
		p_vi_s2 <= ctl_s1.sample * SW'(ctl_s1.idx);
		p_eb_s2 <= SW'(cfg_view.end_frame) * b_s1;
		p_sa_s2 <= cfg_view.start_m1 * a_s1;
		v2hi_s2 <= SW'(p_v2_full[PW-1:SW]);
		a_s2    <= a_s1;
		b_s2    <= b_s1;
	end

	always_comb begin
		win_v = ctl_s2.win ? ctl_s2.sample : '0;
		delta = (ctl_s2.win ? p_vi_s2 : '0) +
			(ctl_s2.tail ? (p_eb_s2 - p_sa_s2 - win_v) : '0);
		vsd   = win_v + (ctl_s2.tail ? (b_s2 - a_s2) : '0);
	end

	always_ff @(posedge clk) begin
		ctl_s3   <= ctl_s2;
		delta_s3 <= delta;
		vsd_s3   <= vsd;
		v2d_s3   <= ctl_s2.v2_in ? v2hi_s2 : '0;
	end

	assign rc_next = rc_q + delta_s3 - (ctl_s3.tail ? vs_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			rc_q     <= '0;
			vs_q     <= '0;
			v2s_q    <= '0;
			base_q   <= '0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s3 && !ctl_s3.reject) begin
				rc_q  <= rc_next;
				vs_q  <= vs_q + vsd_s3;
				v2s_q <= v2s_q + v2d_s3;
				if (ctl_s3.emit && ctl_s3.base_hit) begin
					base_q <= rc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_s4 <= ctl_s3;
	end

	assign done         = valid_s4;
	assign push         = valid_s4 && (ctl_s4.emit || ctl_s4.reject);
	assign entry.reject = ctl_s4.reject;
	assign entry.v2     = ctl_s4.is_final;
	assign entry.offset = ctl_s4.offset;
	assign entry.csum1  = rc_q;
	assign entry.csum2  = v2s_q + base_q;

endmodule

/* hdl/aroc_outq.sv */
// result queue that splits each frame's entry into result transactions
module aroc_outq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  aroc_pkg::res_entry_t        entry,
	aroc_out_if.source                  results,
	output logic [aroc_pkg::QCNT_W-1:0] count
);

	aroc_pkg::res_entry_t          q_mem [aroc_pkg::QDEPTH];
	logic [aroc_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [aroc_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [aroc_pkg::QCNT_W-1:0]   count_q;
	logic                          phase_q;
	aroc_pkg::res_entry_t          head;
	logic                          take;
	logic                          final_sub;
	logic                          pop;

	assign head      = q_mem[rd_ptr_q];
	assign take      = results.valid && results.ready;
	assign final_sub = head.reject || !head.v2 || phase_q;
	assign pop       = take && final_sub;
	assign count     = count_q;

	always_comb begin
		results.valid = count_q != '0;
		if (head.reject) begin
			results.kind     = aroc_pkg::KIND_REJECT;
			results.offset   = '0;
			results.checksum = '0;
			results.last     = 1'b0;
		end else if (phase_q) begin
			results.kind     = aroc_pkg::KIND_V2;
			results.offset   = '0;
			results.checksum = head.csum2;
			results.last     = 1'b1;
		end else begin
			results.kind     = aroc_pkg::KIND_V1;
			results.offset   = head.offset;
			results.checksum = head.csum1;
			results.last     = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + aroc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + aroc_pkg::QPTR_W'(1);
				phase_q  <= 1'b0;
			end else if (take) begin
				phase_q <= 1'b1;
			end
			count_q <= count_q + aroc_pkg::QCNT_W'(push) - aroc_pkg::QCNT_W'(pop);
		end
	end

endmodule

/* hdl/accuraterip_offset_checksum_core.sv */
// AccurateRip v1/v2 offset checksum core, top level.
// Takes one stereo frame per clock, with no bubbles, as long as the result side keeps up.
// Every frame walks a fixed path: the fifo address and window decisions, registered together
// with the leading and trailing fifo reads, then the products, then the term merge, then the
// accumulator update, after which any results it gives are written into the result queue. The
// rate is set by the running checksum register loop. Each frame holds one slot of the
// eight-entry result queue from acceptance until it leaves the pipeline or, if it gives results, until they leave.
// The final frame gives two results, the v1 result at its offset and then the v2 result, so the
// result side needs two transactions for it. The leading and trailing fifos are rams with no
// clearing pass: a frame counter keeps reads inside the written entries, so a frame is accepted
// in the first cycle after reset. Register writes are taken in any cycle; the user must make
// them only while no frame is in flight, as the block does not enforce this.
module accuraterip_offset_checksum_core #(
	parameter int MAX_RANGE = 8192
) (
	input  logic       clk,
	input  logic       arst_n,
	aroc_in_if.sink    samples,
	aroc_out_if.source results,
	aroc_cfg_if.sink   cfg
);

	localparam int AW    = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1;
	localparam int DEPTH = (MAX_RANGE > 1) ? MAX_RANGE - 1 : 1;

	logic                          accept;
	logic                          lead_we;
	logic [AW-1:0]                 lead_waddr;
	logic                          trail_we;
	logic [AW-1:0]                 trail_waddr;
	logic [aroc_pkg::SUM_W-1:0]    wdata;
	logic [AW-1:0]                 raddr;
	logic [aroc_pkg::SUM_W-1:0]    lead_rdata;
	logic [aroc_pkg::SUM_W-1:0]    trail_rdata;
	aroc_pkg::cfg_view_t           cfg_view;
	logic                          valid_s1;
	aroc_pkg::item_ctl_t           ctl_s1;
	logic                          done;
	logic                          push;
	aroc_pkg::res_entry_t          entry;
	logic [aroc_pkg::QCNT_W-1:0]   q_count;
	logic [aroc_pkg::PEND_W-1:0]   pending_q;

	// a queue slot is held for every frame still in the pipeline
	assign samples.ready = ((aroc_pkg::QCNT_W + 1)'(q_count) + (aroc_pkg::QCNT_W + 1)'(pending_q))
		< (aroc_pkg::QCNT_W + 1)'(aroc_pkg::QDEPTH);
	assign accept = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + aroc_pkg::PEND_W'(accept) - aroc_pkg::PEND_W'(done);
		end
	end

	aroc_ctrl #(
		.MAX_RANGE(MAX_RANGE),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.accept(accept),
		.left_sample(samples.left_sample),
		.right_sample(samples.right_sample),
		.lead_we(lead_we),
		.lead_waddr(lead_waddr),
		.trail_we(trail_we),
		.trail_waddr(trail_waddr),
		.wdata(wdata),
		.raddr(raddr),
		.cfg_view(cfg_view),
		.valid_s1(valid_s1),
		.ctl_s1(ctl_s1)
	);

	aroc_ram #(
		.AW(AW),
		.DEPTH(DEPTH)
	) u_lead_ram (
		.clk(clk),
		.we(lead_we),
		.waddr(lead_waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(lead_rdata)
	);

	aroc_ram #(
		.AW(AW),
		.DEPTH(DEPTH)
	) u_trail_ram (
		.clk(clk),
		.we(trail_we),
		.waddr(trail_waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(trail_rdata)
	);

	aroc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.ctl_s1(ctl_s1),
		.cfg_view(cfg_view),
		.lead_rdata(lead_rdata),
		.trail_rdata(trail_rdata),
		.done(done),
		.push(push),
		.entry(entry)
	);

	aroc_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.entry(entry),
		.results(results),
		.count(q_count)
	);

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= aroc_pkg::PEND_W'(aroc_pkg::PIPE_DEPTH))
		else $error("more frames in flight than pipeline stages");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < aroc_pkg::QCNT_W'(aroc_pkg::QDEPTH)))
		else $error("result queue overflow");

	a_v2_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.kind == aroc_pkg::KIND_V2)) |-> results.last)
		else $error("v2 result not marked last");

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("frame left the pipeline without a matching acceptance");

endmodule
